// File: rtl/core/rsp_pkg.sv
`default_nettype none

package rsp_pkg;

  // fixed point and field widths
  localparam int FRAC_BITS  = 16;
  localparam int COL_W      = 12;
  localparam int PIX_W      = 32;
  localparam int LEN_W      = 13;
  localparam int ANG_W      = 17;
  localparam int RGB_W      = 24;
  localparam int X_W        = 14;
  localparam int PROD_W     = 32;
  localparam int DIST_W     = 15;
  localparam int SHIFT_W    = DIST_W + 1;
  localparam int PER_W      = LEN_W + 1;

  // port widths
  localparam int IN_TDATA_W  = 2 * COL_W + PIX_W;
  localparam int OUT_TDATA_W = PIX_W;
  localparam int REG_IDX_W   = 3;
  localparam int CFG_W       = RGB_W;

  // remainder pipeline: DIV_STAGES * DIV_PER_STG must equal DIST_W
  localparam int DIV_STAGES  = 5;
  localparam int DIV_PER_STG = 3;

  localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_LINE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAP    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COS    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SIN    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIRROR = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FILL   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd7;

  // register reset values
  localparam logic [ANG_W-1:0] COS_RST   = 17'd65536;
  localparam logic [RGB_W-1:0] FILL_RST  = 24'hFF6432;
  localparam logic [LEN_W-1:0] WIDTH_RST = 13'd4096;

  typedef logic [DIST_W-1:0] rem_t;
  typedef logic [PER_W-1:0]  per_t;

  // one restoring step: take per << sh off rem if it fits
  function automatic rem_t div_step(rem_t rem, per_t per, int unsigned sh);
    rem_t hi;
    rem_t per_ext;
    hi      = rem >> sh;
    per_ext = rem_t'(per);
    if (hi >= per_ext)
      div_step = rem - (per_ext << sh);
    else
      div_step = rem;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rotated_stripe_pattern.sv
`default_nettype none

// channel  | direction | fields (lowest bit first)
// ---------+-----------+-------------------------------------------------
// in_      | slave     | tdata: column[11:0], row[23:12], source_pixel[55:24]
// out_     | master    | tdata: pixel_out[31:0]; tuser: in_stripe
// cfg_     | write     | cfg_index selects register, cfg_data its value
//
// one item per clock sustained while out_tready holds, ten register stages from accept to out_tvalid
// stages: mirror, two multipliers, sum and abs, offset, five remainder stages
// (three restoring steps each), output register
// rst_n is synchronous; it clears valid bits and restores register defaults
// each stage holds its item only while the stage after it is full and stalled,
// so bubbles close up; in_tready drops only once all ten stages hold items
// and the output is stalled

module rotated_stripe_pattern
  import rsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // column, row, source_pixel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // pixel_out
  output logic                   out_tuser,  // in_stripe
  input  logic                   cfg_we,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int DIV_FIRST = 4;
  localparam int OUT_STG   = DIV_FIRST + DIV_STAGES;
  localparam int STG_N     = OUT_STG + 1;
  localparam int DIV_LAST  = DIV_STAGES - 1;

  // configuration registers
  logic        [LEN_W-1:0] line_r;
  logic        [LEN_W-1:0] gap_r;
  logic signed [LEN_W-1:0] offset_r;
  logic        [ANG_W-1:0] cos_r;
  logic        [ANG_W-1:0] sin_r;
  logic                    mirror_r;
  logic        [RGB_W-1:0] fill_r;
  logic        [LEN_W-1:0] width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r   <= '0;
      gap_r    <= '0;
      offset_r <= '0;
      cos_r    <= COS_RST;
      sin_r    <= '0;
      mirror_r <= 1'b0;
      fill_r   <= FILL_RST;
      width_r  <= WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE:   line_r   <= cfg_data[LEN_W-1:0];
        REG_GAP:    gap_r    <= cfg_data[LEN_W-1:0];
        REG_OFFSET: offset_r <= cfg_data[LEN_W-1:0];
        REG_COS:    cos_r    <= cfg_data[ANG_W-1:0];
        REG_SIN:    sin_r    <= cfg_data[ANG_W-1:0];
        REG_MIRROR: mirror_r <= cfg_data[0];
        REG_FILL:   fill_r   <= cfg_data[RGB_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // period of the pattern, zero disables painting
  per_t period;
  assign period = per_t'(line_r) + per_t'(gap_r);

  // valid bits and per-stage ready chain
  logic [STG_N-1:0] vld_r;
  logic [STG_N-1:0] rdy;

  always_comb begin
    rdy[OUT_STG] = !vld_r[OUT_STG] || out_tready;
    for (int k = OUT_STG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_tvalid;
      for (int k = 1; k < STG_N; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // unpack the input item
  logic [COL_W-1:0] in_col;
  logic [COL_W-1:0] in_row;
  logic [PIX_W-1:0] in_src;
  assign in_col = in_tdata[COL_W-1:0];
  assign in_row = in_tdata[2*COL_W-1:COL_W];
  assign in_src = in_tdata[IN_TDATA_W-1:2*COL_W];

  // source pixel rides along every stage ahead of the output register
  logic [PIX_W-1:0] src_r [OUT_STG];

  // stage 0: reflected column, may go negative
  logic signed [X_W-1:0]   x_r, x_nxt;
  logic        [COL_W-1:0] row_r;

  assign x_nxt = mirror_r ? (X_W'(width_r) - X_W'(in_col) - X_W'(1)) : X_W'(in_col);

  // stage 1: the two projections
  logic signed [PROD_W-1:0] px_r, px_nxt;
  logic        [PROD_W-1:0] py_r, py_nxt;

  assign px_nxt = $signed({{(PROD_W-X_W){x_r[X_W-1]}}, x_r})
                * $signed({{(PROD_W-ANG_W){1'b0}}, cos_r});
  assign py_nxt = {{(PROD_W-COL_W){1'b0}}, row_r} * {{(PROD_W-ANG_W){1'b0}}, sin_r};

  // stage 2: magnitude of the sum, integer part
  logic signed [PROD_W-1:0] proj;
  logic        [PROD_W-1:0] mag;
  logic        [DIST_W-1:0] dist_r, dist_nxt;

  assign proj     = px_r + $signed(py_r);
  assign mag      = proj[PROD_W-1] ? PROD_W'(-proj) : PROD_W'(proj);
  assign dist_nxt = mag[FRAC_BITS +: DIST_W];

  // stage 3: apply offset, negative distances never paint
  logic signed [SHIFT_W-1:0] shifted;
  logic signed [SHIFT_W-1:0] shift_r;
  assign shifted = $signed({1'b0, dist_r})
                 - $signed({{(SHIFT_W-LEN_W){offset_r[LEN_W-1]}}, offset_r});

  // stages 4..8: restoring remainder, three quotient bits per stage
  rem_t div_rem_r  [DIV_STAGES];
  logic div_cand_r [DIV_STAGES];
  rem_t div_rem_nxt [DIV_STAGES];

  always_comb begin
    rem_t r;
    for (int k = 0; k < DIV_STAGES; k++) begin
      r = (k == 0) ? rem_t'(shift_r[DIST_W-1:0]) : div_rem_r[(k == 0) ? 0 : k-1];
      for (int j = 0; j < DIV_PER_STG; j++) begin
        r = div_step(r, period, DIST_W - 1 - (k * DIV_PER_STG + j));
      end
      div_rem_nxt[k] = r;
    end
  end

  // stage 9: output register
  logic             stripe_nxt;
  logic [PIX_W-1:0] pix_nxt;
  logic [PIX_W-1:0] pix_r;
  logic             stripe_r;

  assign stripe_nxt = div_cand_r[DIV_LAST] && (div_rem_r[DIV_LAST] > rem_t'(gap_r));
  assign pix_nxt    = stripe_nxt ? {fill_r, OPAQUE_ALPHA} : src_r[OUT_STG-1];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x_r      <= x_nxt;
      row_r    <= in_row;
      src_r[0] <= in_src;
    end
    for (int k = 1; k < OUT_STG; k++) begin
      if (rdy[k]) src_r[k] <= src_r[k-1];
    end
    if (rdy[1]) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
    if (rdy[2]) dist_r <= dist_nxt;
    if (rdy[3]) shift_r <= shifted;
    if (rdy[DIV_FIRST]) begin
      div_rem_r[0]  <= div_rem_nxt[0];
      div_cand_r[0] <= !shift_r[SHIFT_W-1] && (period != '0);
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (rdy[DIV_FIRST+k]) begin
        div_rem_r[k]  <= div_rem_nxt[k];
        div_cand_r[k] <= div_cand_r[k-1];
      end
    end
    if (rdy[OUT_STG]) begin
      pix_r    <= pix_nxt;
      stripe_r <= stripe_nxt;
    end
  end

  assign out_tvalid = vld_r[OUT_STG];
  assign out_tdata  = pix_r;
  assign out_tuser  = stripe_r;

  // an empty output register lets the whole chain move
  a_ready_when_out_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[OUT_STG] |-> in_tready)
    else $error("input stalled with empty output stage");

  // an accepted item lands in the first stage
  a_accept_fills_first : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted item lost at first stage");

  // painted pixels carry opaque alpha
  a_stripe_opaque : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[7:0] == OPAQUE_ALPHA))
    else $error("stripe pixel without opaque alpha");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import rsp_pkg::*;
();

  // run limits in clock cycles, and items per random chunk
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam int CHUNK_ITEMS  = 24;

  // shadow copy of the register file, one member per register index
  typedef struct {
    logic        [LEN_W-1:0] line_px;
    logic        [LEN_W-1:0] gap_px;
    logic signed [LEN_W-1:0] offset_px;
    logic        [ANG_W-1:0] cos_q;
    logic        [ANG_W-1:0] sin_q;
    logic                    mirror;
    logic        [RGB_W-1:0] fill_rgb;
    logic        [LEN_W-1:0] image_width;
  } stripe_cfg_t;

  // one predicted output item
  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             stripe;
  } pixel_result_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // column, row, source_pixel
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // pixel_out
  logic                   out_tuser;        // in_stripe
  logic                   cfg_we     = 1'b0;
  logic [REG_IDX_W-1:0]   cfg_index  = REG_LINE;
  logic [CFG_W-1:0]       cfg_data   = '0;

  stripe_cfg_t   regs_now;
  pixel_result_t expected_pixels[$];
  pixel_result_t head_pixel;
  int            mismatches     = 0;
  int            cycle_count    = 0;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  int            hold_off       = 0;

  rotated_stripe_pattern dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // register values right after reset
  function automatic stripe_cfg_t plain_settings();
    stripe_cfg_t s;
    s.line_px     = '0;
    s.gap_px      = '0;
    s.offset_px   = '0;
    s.cos_q       = COS_RST;
    s.sin_q       = '0;
    s.mirror      = 1'b0;
    s.fill_rgb    = FILL_RST;
    s.image_width = WIDTH_RST;
    return s;
  endfunction

  // expected output for one pixel under the given register settings
  function automatic pixel_result_t predict_pixel(stripe_cfg_t c, logic [COL_W-1:0] col,
                                                  logic [COL_W-1:0] row, logic [PIX_W-1:0] src);
    longint        period;
    longint        x;
    longint        proj;
    longint        distance;
    longint        shifted;
    pixel_result_t r;
    r.pixel  = src;
    r.stripe = 1'b0;
    period   = longint'(c.line_px) + longint'(c.gap_px);
    if (period > 0) begin
      // reflected column may go negative; no wrap
      x = c.mirror ? (longint'(c.image_width) - 1 - longint'(col)) : longint'(col);
      proj = x * longint'(c.cos_q) + longint'(row) * longint'(c.sin_q);
      // floor of the magnitude, not of the signed value
      if (proj < 0)
        proj = -proj;
      distance = proj >> FRAC_BITS;
      shifted  = distance - longint'(c.offset_px);
      // negative distance after the shift never paints
      if (shifted >= 0 && (shifted % period) > longint'(c.gap_px)) begin
        r.pixel  = {c.fill_rgb, OPAQUE_ALPHA};
        r.stripe = 1'b1;
      end
    end
    return r;
  endfunction

  // mix of nominal settings and the corners of every register
  function automatic stripe_cfg_t random_settings();
    stripe_cfg_t s;
    int          off;
    s.line_px     = LEN_W'($urandom_range(40, 1));
    s.gap_px      = LEN_W'($urandom_range(40, 0));
    off           = ($urandom_range(9, 0) == 0) ? int'($urandom_range(4095, 1))
                                                : -int'($urandom_range(4096, 0));
    s.offset_px   = off[LEN_W-1:0];
    s.cos_q       = ($urandom_range(9, 0) == 0) ? ANG_W'($urandom_range(131071, 65537))
                                                : ANG_W'($urandom_range(65536, 0));
    s.sin_q       = ($urandom_range(9, 0) == 0) ? ANG_W'($urandom_range(131071, 65537))
                                                : ANG_W'($urandom_range(65536, 0));
    s.mirror      = 1'($urandom_range(1, 0));
    s.fill_rgb    = RGB_W'($urandom());
    case ($urandom_range(7, 0))
      0: s.image_width = '0;
      1: s.image_width = LEN_W'($urandom_range(8191, 4097));
      default: s.image_width = LEN_W'($urandom_range(4096, 1));
    endcase
    case ($urandom_range(11, 0))
      0: begin
        // everything at its top end, offset at either end
        s.line_px     = '1;
        s.gap_px      = '1;
        s.offset_px   = $urandom_range(1, 0) ? 13'sh0fff : 13'sh1000;
        s.cos_q       = '1;
        s.sin_q       = '1;
        s.mirror      = 1'b1;
        s.fill_rgb    = '1;
        s.image_width = '1;
      end
      1: begin
        // everything at its bottom end
        s.line_px     = '0;
        s.gap_px      = LEN_W'($urandom_range(1, 0));
        s.line_px     = LEN_W'(1 - s.gap_px);
        s.offset_px   = 13'sh1000;
        s.cos_q       = '0;
        s.sin_q       = '0;
        s.mirror      = 1'b0;
        s.fill_rgb    = '0;
        s.image_width = '0;
      end
      2: begin
        s.line_px = '0;
        s.gap_px  = '0;
      end
      3: s.line_px = LEN_W'($urandom_range(8191, 0));
      4: s.gap_px  = LEN_W'($urandom_range(8191, 0));
      default: ;
    endcase
    return s;
  endfunction

  // one register write; the shadow copy follows at once since the block is idle
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_LINE:   regs_now.line_px     = value[LEN_W-1:0];
      REG_GAP:    regs_now.gap_px      = value[LEN_W-1:0];
      REG_OFFSET: regs_now.offset_px   = value[LEN_W-1:0];
      REG_COS:    regs_now.cos_q       = value[ANG_W-1:0];
      REG_SIN:    regs_now.sin_q       = value[ANG_W-1:0];
      REG_MIRROR: regs_now.mirror      = value[0];
      REG_FILL:   regs_now.fill_rgb    = value[RGB_W-1:0];
      default:    regs_now.image_width = value[LEN_W-1:0];
    endcase
    @(negedge clk);
  endtask

  task automatic load_settings(input stripe_cfg_t s);
    write_reg(REG_LINE,   CFG_W'(s.line_px));
    write_reg(REG_GAP,    CFG_W'(s.gap_px));
    write_reg(REG_OFFSET, CFG_W'(s.offset_px[LEN_W-1:0]));
    write_reg(REG_COS,    CFG_W'(s.cos_q));
    write_reg(REG_SIN,    CFG_W'(s.sin_q));
    write_reg(REG_MIRROR, CFG_W'(s.mirror));
    write_reg(REG_FILL,   CFG_W'(s.fill_rgb));
    write_reg(REG_WIDTH,  CFG_W'(s.image_width));
    cfg_we <= 1'b0;
  endtask

  // offer one pixel, with random idle cycles in front; entered at a falling edge
  task automatic send_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
                            input logic [PIX_W-1:0] src);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {src, row, col};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    expected_pixels.push_back(predict_pixel(regs_now, col, row, src));
    @(negedge clk);
  endtask

  // columns cluster around the reflection edge now and then
  task automatic send_random_pixel();
    logic [COL_W-1:0] col;
    if (regs_now.mirror && $urandom_range(3, 0) == 0)
      col = COL_W'(int'(regs_now.image_width) + int'($urandom_range(4, 0)) - 2);
    else
      col = COL_W'($urandom_range(4095, 0));
    send_pixel(col, COL_W'($urandom_range(4095, 0)), $urandom());
  endtask

  // stop offering and let every predicted pixel come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0)
      @(negedge clk);
  endtask

  // zero period passes through, then the reset cosine and fill show up
  task automatic test_reset_values();
    send_pixel(12'd0, 12'd0, 32'h0000_0000);
    send_pixel(12'd4095, 12'd4095, 32'hffff_ffff);
    send_pixel(12'd5, 12'd9, 32'h1234_5678);
    wait_idle();
    write_reg(REG_LINE, CFG_W'(3));
    write_reg(REG_GAP, CFG_W'(1));
    cfg_we <= 1'b0;
    for (int c = 0; c < 4; c++)
      send_pixel(COL_W'(c), 12'd0, 32'h5a5a_a5a5);
    wait_idle();
  endtask

  // remainder equal to the gap passes, one above it paints
  task automatic test_stripe_edges();
    stripe_cfg_t s;
    s          = plain_settings();
    s.line_px  = 13'd2;
    s.gap_px   = 13'd3;
    s.fill_rgb = '0;
    load_settings(s);
    send_pixel(12'd3, 12'd4095, 32'hffff_ffff);
    send_pixel(12'd4, 12'd4095, 32'hffff_ffff);
    send_pixel(12'd5, 12'd4095, 32'hffff_ffff);
    wait_idle();
    s.sin_q    = 17'd65536;
    s.fill_rgb = '1;
    load_settings(s);
    send_pixel(12'd4095, 12'd4095, 32'h0000_0000);
    send_pixel(12'd4094, 12'd0, 32'h0000_0000);
    wait_idle();
  endtask

  // reflected column below zero, including a zero width and a fractional cosine
  task automatic test_mirror();
    stripe_cfg_t s;
    s             = plain_settings();
    s.line_px     = 13'd4;
    s.mirror      = 1'b1;
    s.image_width = 13'd10;
    s.fill_rgb    = 24'h13579b;
    load_settings(s);
    send_pixel(12'd0, 12'd0, 32'h0102_0304);
    send_pixel(12'd9, 12'd0, 32'h0102_0304);
    send_pixel(12'd10, 12'd0, 32'h0102_0304);
    send_pixel(12'd4095, 12'd0, 32'h0102_0304);
    wait_idle();
    s.cos_q = 17'd32768;
    load_settings(s);
    send_pixel(12'd10, 12'd0, 32'hcafe_f00d);
    send_pixel(12'd12, 12'd0, 32'hcafe_f00d);
    wait_idle();
    s.cos_q       = COS_RST;
    s.image_width = '0;
    load_settings(s);
    send_pixel(12'd0, 12'd0, 32'hdead_beef);
    wait_idle();
  endtask

  // positive shift pushes small distances below zero, which always passes through
  task automatic test_positive_offset();
    stripe_cfg_t s;
    s           = plain_settings();
    s.line_px   = 13'd3;
    s.gap_px    = 13'd1;
    s.offset_px = 13'sd100;
    load_settings(s);
    send_pixel(12'd0, 12'd7, 32'h1111_1111);
    send_pixel(12'd99, 12'd7, 32'h2222_2222);
    send_pixel(12'd102, 12'd7, 32'h3333_3333);
    send_pixel(12'd103, 12'd7, 32'h4444_4444);
    wait_idle();
  endtask

  // largest period, angles above one and a wide reflected column
  task automatic test_wide_values();
    stripe_cfg_t s;
    s             = plain_settings();
    s.line_px     = '1;
    s.gap_px      = '1;
    s.offset_px   = 13'sh1000;
    s.cos_q       = '1;
    s.sin_q       = '1;
    s.mirror      = 1'b1;
    s.image_width = '1;
    s.fill_rgb    = 24'h80ff01;
    load_settings(s);
    send_pixel(12'd0, 12'd4095, 32'h8000_0001);
    send_pixel(12'd4095, 12'd0, 32'h7fff_fffe);
    send_pixel(12'd2048, 12'd2048, 32'haaaa_5555);
    wait_idle();
  endtask

  // random settings in chunks, each chunk drained before the next write
  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int chunks);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < chunks; k++) begin
      load_settings(random_settings());
      repeat (CHUNK_ITEMS)
        send_random_pixel();
      wait_idle();
    end
  endtask

  // receiver holds off long enough that the pipeline fills and in_tready drops
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_settings(random_settings());
    hold_off = 150;
    repeat (40)
      send_random_pixel();
    wait_idle();
  endtask

  // receiver side: long hold-off first, random stalls otherwise
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off = hold_off - 1;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // compare every accepted output item with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected output item: pixel_out %h in_stripe %b", out_tdata, out_tuser);
        mismatches++;
      end else begin
        head_pixel = expected_pixels.pop_front();
        if (out_tdata !== head_pixel.pixel) begin
          $error("pixel_out mismatch: expected %h, actual %h", head_pixel.pixel, out_tdata);
          mismatches++;
        end
        if (out_tuser !== head_pixel.stripe) begin
          $error("in_stripe mismatch: expected %b, actual %b", head_pixel.stripe, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    regs_now = plain_settings();
    repeat (8)
      @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_values();
    test_stripe_edges();
    test_mirror();
    test_positive_offset();
    test_wide_values();

    // no idling, sender idle, receiver stalling, both a little
    test_random_phase(0, 0, 4);
    test_random_phase(86, 0, 4);
    test_random_phase(0, 86, 4);
    test_random_phase(12, 12, 4);
    test_backpressure();

    // catch any stray item after the last expected one
    wait_idle();
    repeat (DRAIN_CYCLES)
      @(negedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: rotated_stripe_pattern.f
rtl/core/rsp_pkg.sv
rtl/core/rotated_stripe_pattern.sv
tb/tb_top.sv
